// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file smc_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smc check failed");

// next-cycle implication, disabled while reset is low
`define SMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smc check failed");

`endif

// ----- src/smc_pkg.sv -----
// Package of the spectral masking comparator: types, codes and fixed widths.
// No dependencies.
package smc_pkg;

    localparam int SMP_W      = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAN_OUT_W = 7;
    localparam int COEF_CH_W  = 7;
    localparam int COEF_TAP_W = 5;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW   = 2'd1;

    localparam logic [7:0] CHANNEL_COUNT_RST = 8'd128;
    localparam logic [3:0] HALF_WINDOW_RST   = 4'd8;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_mac_ctl;

endpackage

// ----- src/smc_mac.sv -----
// Shared multiply-accumulate unit: one registered multiplier feeding an accumulator.
// Depends on smc_pkg (t_mac_ctl).
module smc_mac #(
    parameter int A_W   = 16,
    parameter int B_W   = 16,
    parameter int ACC_W = 37
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smc_pkg::t_mac_ctl    i_ctl,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [ACC_W-1:0]     o_acc,
    output logic                 o_busy
);

    logic [A_W+B_W-1:0] r_prod;
    logic               r_pv;
    logic [ACC_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_pv;

endmodule

// ----- src/spectral_masking_comparator.sv -----
// Top level of the spectral masking comparator: frame and coefficient stores,
// decision sequencer and output register. Depends on smc_pkg and smc_mac.
//
//  channel   dir  tdata fields (low bit up)                              side
//  s_axis    in   sample[15:0] coef_channel[22:16] coef_tap[27:23]       tuser = cmd
//                 coef_value[43:28] zero[47:44]
//  m_axis    out  channel[6:0] above_mask[7]                             tlast = last
//  cfg       in   write enable, index, data (0 channel_count, 1 half_window)
//
// A coefficient load or a sample is taken only in the idle state. Each decision that a sample
// releases is computed by the single multiplier, which runs one tap per cycle over the frame
// and coefficient memory read ports; the input side is not ready until the last one is out.
// Reset clears control and configuration only; both stores are unset until written.
// A pending result in the output register stalls the sequencer, not the input side.
module spectral_masking_comparator #(
    parameter int MAX_CHANNELS    = 128,
    parameter int MAX_HALF_WINDOW = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [smc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // sample, coef_channel, coef_tap, coef_value
    input  logic                                i_s_axis_tuser,  // cmd
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [smc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,  // channel, above_mask
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [smc_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int TAPS  = 2 * MAX_HALF_WINDOW + 1;
    localparam int CH_W  = $clog2(MAX_CHANNELS);
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int TAP_W = $clog2(TAPS + 1);
    localparam int CA_W  = $clog2(MAX_CHANNELS * TAPS);
    localparam int PW    = ((CNT_W > smc_pkg::CFG_W) ? CNT_W : smc_pkg::CFG_W) + 1;
    localparam int IDX_W = PW + 1;
    localparam int ACC_W = smc_pkg::SMP_W + smc_pkg::COEF_W + $clog2(TAPS);

    // input fields
    logic [smc_pkg::SMP_W-1:0]      in_sample;
    logic [smc_pkg::COEF_CH_W-1:0]  in_coef_ch;
    logic [smc_pkg::COEF_TAP_W-1:0] in_coef_tap;
    logic [smc_pkg::COEF_W-1:0]     in_coef_val;

    assign in_sample   = i_s_axis_tdata[15:0];
    assign in_coef_ch  = i_s_axis_tdata[22:16];
    assign in_coef_tap = i_s_axis_tdata[27:23];
    assign in_coef_val = i_s_axis_tdata[43:28];

    // configuration
    logic [7:0] r_cfg_count;
    logic [3:0] r_cfg_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count  <= smc_pkg::CHANNEL_COUNT_RST;
            r_cfg_window <= smc_pkg::HALF_WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smc_pkg::CFG_CHANNEL_COUNT: r_cfg_count  <= i_cfg_data;
                smc_pkg::CFG_HALF_WINDOW:   r_cfg_window <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [PW-1:0] cfg_cnt_x;
    logic [PW-1:0] cnt_x;
    logic [PW-1:0] cnt_m1;
    logic [PW-1:0] w_x;

    assign cfg_cnt_x = PW'(r_cfg_count);
    assign cnt_x = (cfg_cnt_x == '0) ? PW'(1) :
                   (cfg_cnt_x > PW'(MAX_CHANNELS)) ? PW'(MAX_CHANNELS) : cfg_cnt_x;
    assign cnt_m1 = cnt_x - PW'(1);
    assign w_x = (PW'(r_cfg_window) > PW'(MAX_HALF_WINDOW)) ? PW'(MAX_HALF_WINDOW)
                                                            : PW'(r_cfg_window);

    // state
    smc_pkg::t_state r_state, n_state;
    logic [CH_W-1:0]    r_pos;
    logic [CH_W-1:0]    r_k;
    logic [CH_W-1:0]    r_k_end;
    logic signed [IDX_W-1:0] r_idx;
    logic [CA_W-1:0]    r_caddr;
    logic [TAP_W-1:0]   r_left;
    logic               r_rd_v;
    logic               r_ctr_v;
    logic [smc_pkg::SMP_W-1:0] r_center;
    logic               r_out_valid;
    logic [smc_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic               r_out_last;

    logic s_accept;
    logic acc_sample;
    logic acc_coef;
    logic out_free;
    logic out_load;
    logic mac_busy;
    logic [ACC_W-1:0] mac_acc;
    logic above;

    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_sample = s_accept && (i_s_axis_tuser == smc_pkg::CMD_SAMPLE);
    assign acc_coef   = s_accept && (i_s_axis_tuser == smc_pkg::CMD_COEF);
    assign out_free   = !r_out_valid || i_m_axis_tready;

    // emission range of an arriving sample
    logic [PW-1:0] p_x;
    logic          frame_end;
    logic          p_ge_w;
    logic [PW-1:0] k_first_x;
    logic [PW-1:0] k_end_x;
    logic          emit_any;

    always_comb begin
        p_x       = PW'(r_pos);
        frame_end = (p_x + PW'(1)) >= cnt_x;
        p_ge_w    = p_x >= w_x;
        k_first_x = p_ge_w ? (p_x - w_x) : '0;
        if (frame_end) begin
            emit_any = k_first_x < cnt_x;
            k_end_x  = cnt_m1;
        end else begin
            emit_any = p_ge_w;
            k_end_x  = k_first_x;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smc_pkg::ST_IDLE:  if (acc_sample && emit_any) n_state = smc_pkg::ST_START;
            smc_pkg::ST_START: n_state = smc_pkg::ST_ISSUE;
            smc_pkg::ST_ISSUE: if (r_left == TAP_W'(1)) n_state = smc_pkg::ST_DRAIN;
            smc_pkg::ST_DRAIN: if (!r_rd_v && !mac_busy) n_state = smc_pkg::ST_OUT;
            smc_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = (r_k == r_k_end) ? smc_pkg::ST_IDLE : smc_pkg::ST_START;
                end
            end
            default: n_state = smc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    logic              frame_rd_en;
    logic [CH_W-1:0]   frame_rd_addr;
    logic [CH_W-1:0]   tap_addr;
    logic              coef_rd_en;
    smc_pkg::t_mac_ctl mac_ctl;

    always_comb begin
        if (r_idx[IDX_W-1]) begin
            tap_addr = '0;
        end else if (r_idx[PW-1:0] > cnt_m1) begin
            tap_addr = CH_W'(cnt_m1);
        end else begin
            tap_addr = CH_W'(r_idx[PW-1:0]);
        end
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        frame_rd_en     = 1'b0;
        frame_rd_addr   = tap_addr;
        coef_rd_en      = 1'b0;
        mac_ctl.clr     = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            smc_pkg::ST_IDLE:  o_s_axis_tready = 1'b1;
            smc_pkg::ST_START: begin
                frame_rd_en   = 1'b1;
                frame_rd_addr = r_k;
                mac_ctl.clr   = 1'b1;
            end
            smc_pkg::ST_ISSUE: begin
                frame_rd_en = 1'b1;
                coef_rd_en  = 1'b1;
            end
            smc_pkg::ST_DRAIN: ;
            smc_pkg::ST_OUT:   out_load = out_free;
            default: ;
        endcase
        mac_ctl.vld = r_rd_v;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smc_pkg::ST_IDLE;
            r_pos       <= '0;
            r_rd_v      <= 1'b0;
            r_ctr_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= coef_rd_en;
            r_ctr_v <= (r_state == smc_pkg::ST_START);
            if (acc_sample) begin
                r_pos <= frame_end ? '0 : r_pos + CH_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (acc_sample) begin
            r_k     <= CH_W'(k_first_x);
            r_k_end <= CH_W'(k_end_x);
        end else if (out_load) begin
            r_k <= r_k + CH_W'(1);
        end
        if (r_state == smc_pkg::ST_START) begin
            r_idx   <= IDX_W'(r_k) - IDX_W'(w_x);
            r_caddr <= CA_W'(r_k) * CA_W'(TAPS) + CA_W'(MAX_HALF_WINDOW) - CA_W'(w_x);
            r_left  <= TAP_W'({w_x, 1'b1});
        end else if (r_state == smc_pkg::ST_ISSUE) begin
            r_idx   <= r_idx + IDX_W'(1);
            r_caddr <= r_caddr + CA_W'(1);
            r_left  <= r_left - TAP_W'(1);
        end
        if (r_ctr_v) begin
            r_center <= r_frame_q;
        end
        if (out_load) begin
            r_out_data <= {above, smc_pkg::CHAN_OUT_W'(r_k)};
            r_out_last <= (r_k == r_k_end);
        end
    end

    // frame store
    logic [smc_pkg::SMP_W-1:0] r_frame_mem [MAX_CHANNELS];
    logic [smc_pkg::SMP_W-1:0] r_frame_q;

    always_ff @(posedge i_clk) begin
        if (acc_sample) begin
            r_frame_mem[r_pos] <= in_sample;
        end
        if (frame_rd_en) begin
            r_frame_q <= r_frame_mem[frame_rd_addr];
        end
    end

    // coefficient store
    logic [smc_pkg::COEF_W-1:0] r_coef_mem [MAX_CHANNELS * TAPS];
    logic [smc_pkg::COEF_W-1:0] r_coef_q;
    logic                       coef_wr_ok;
    logic [CA_W-1:0]            coef_wr_addr;

    assign coef_wr_ok   = (PW'(in_coef_ch) < PW'(MAX_CHANNELS)) &&
                          (PW'(in_coef_tap) < PW'(TAPS));
    assign coef_wr_addr = CA_W'(in_coef_ch) * CA_W'(TAPS) + CA_W'(in_coef_tap);

    always_ff @(posedge i_clk) begin
        if (acc_coef && coef_wr_ok) begin
            r_coef_mem[coef_wr_addr] <= in_coef_val;
        end
        if (coef_rd_en) begin
            r_coef_q <= r_coef_mem[r_caddr];
        end
    end

    smc_mac #(
        .A_W   (smc_pkg::SMP_W),
        .B_W   (smc_pkg::COEF_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (r_frame_q),
        .i_b     (r_coef_q),
        .o_acc   (mac_acc),
        .o_busy  (mac_busy)
    );

    assign above = ACC_W'({r_center, {smc_pkg::COEF_FRAC{1'b0}}}) > mac_acc;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- src/smc_checker.sv -----
// Port-level checks for the spectral masking comparator, bound to the top level.
// Depends on assert_macros.svh and smc_pkg.
`include "assert_macros.svh"

module smc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [smc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                            i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [smc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tlast,
    input logic                            i_cfg_we,
    input logic [smc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [smc_pkg::CFG_W-1:0]       i_cfg_data
);

    logic stall;
    logic coef_req;

    assign stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign coef_req = i_s_axis_tvalid && o_s_axis_tready &&
                      (i_s_axis_tuser == smc_pkg::CMD_COEF);

    `SMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, o_m_axis_tvalid)
    `SMC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, stall, $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
    `SMC_ASSERT_NEXT(a_coef_ready, i_clk, i_rst_n, coef_req, o_s_axis_tready)
    `SMC_ASSERT_NOW(a_result_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

endmodule

bind spectral_masking_comparator smc_checker u_smc_checker (.*);

// ----- tb/spectral_masking_comparator_tb.sv -----
// Self-checking testbench of spectral_masking_comparator: directed table, then random phases
// over several channel counts and window widths, checked against a behavioral predictor.
// Depends on smc_pkg and the spectral_masking_comparator RTL.
module spectral_masking_comparator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smc_pkg::*;

    localparam int MAXC   = 128;
    localparam int MAXW   = 15;
    localparam int TAPS   = 2 * MAXW + 1;
    localparam int SETTLE = 640;
    localparam int HOLD   = 2500;
    localparam int LIMIT  = 400000;
    localparam int DIR_N  = 20;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_LOAD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] smp;
        logic [6:0]  cch;
        logic [4:0]  ctap;
        logic [15:0] cval;
        logic [7:0]  cfg_cnt;
        logic [7:0]  cfg_win;
        logic        n_exp;
        logic [6:0]  e_ch;
        logic        e_above;
    } dir_row_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       above;
        logic       last;
    } decision_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // sample, coef_channel, coef_tap, coef_value
    logic                   i_s_axis_tuser = 1'b0; // cmd
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // channel, above_mask
    logic                   o_m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    spectral_masking_comparator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] frame_mem [MAXC];
    logic [15:0] coef_mem [MAXC][TAPS];
    int          pos_m = 0;
    logic [7:0]  cnt_m = CHANNEL_COUNT_RST;
    logic [3:0]  win_m = HALF_WINDOW_RST;

    decision_t   decisions_due[$];
    decision_t   fresh_q[$];
    decision_t   got_d;
    decision_t   want_d;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;
    dir_row_t    dir_tab [DIR_N];

    function automatic int live_count();
        if (cnt_m == 8'd0) return 1;
        if (int'(cnt_m) > MAXC) return MAXC;
        return int'(cnt_m);
    endfunction

    function automatic int live_window();
        if (int'(win_m) > MAXW) return MAXW;
        return int'(win_m);
    endfunction

    function automatic logic masked_above(int k, int c, int w);
        logic [63:0] acc;
        int          idx;
        acc = '0;
        for (int m = -w; m <= w; m++) begin
            idx = k + m;
            if (idx < 0) idx = 0;
            if (idx > c - 1) idx = c - 1;
            acc += 64'(frame_mem[idx]) * 64'(coef_mem[k][m + MAXW]);
        end
        return (64'(frame_mem[k]) << COEF_FRAC) > acc;
    endfunction

    function automatic void predict_sample(logic [15:0] smp);
        int        c;
        int        w;
        int        p;
        decision_t d;
        c = live_count();
        w = live_window();
        p = pos_m;
        fresh_q.delete();
        if (p >= MAXC) p = MAXC - 1;
        frame_mem[p] = smp;
        if (p + 1 < c) begin
            if (p >= w) begin
                d.ch    = 7'(p - w);
                d.above = masked_above(p - w, c, w);
                d.last  = 1'b1;
                fresh_q.push_back(d);
            end
            pos_m = p + 1;
        end else begin
            for (int k = (p >= w) ? p - w : 0; k < c; k++) begin
                d.ch    = 7'(k);
                d.above = masked_above(k, c, w);
                d.last  = (k == c - 1);
                fresh_q.push_back(d);
            end
            pos_m = 0;
        end
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_coef(int w);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 32768 / (2 * w + 1)));
    endfunction

    function automatic dir_row_t sample_row(logic [15:0] smp, logic n_exp, logic [6:0] e_ch,
                                            logic e_above);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_SAMPLE;
        r.smp     = smp;
        r.n_exp   = n_exp;
        r.e_ch    = e_ch;
        r.e_above = e_above;
        return r;
    endfunction

    function automatic dir_row_t load_row(logic [6:0] cch, logic [4:0] ctap, logic [15:0] cval);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_LOAD;
        r.cch  = cch;
        r.ctap = ctap;
        r.cval = cval;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [7:0] cnt, logic [7:0] win);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.cfg_cnt = cnt;
        r.cfg_win = win;
        return r;
    endfunction

    task automatic send_request(logic cmd, logic [15:0] smp, logic [6:0] cch, logic [4:0] ctap,
                                logic [15:0] cval);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {4'b0, cval, ctap, cch, smp};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_sample(logic [15:0] smp, bit use_model);
        send_request(CMD_SAMPLE, smp, 7'($urandom), 5'($urandom), 16'($urandom));
        predict_sample(smp);
        if (use_model) begin
            foreach (fresh_q[j]) decisions_due.push_back(fresh_q[j]);
        end
    endtask

    task automatic send_load(logic [6:0] cch, logic [4:0] ctap, logic [15:0] cval);
        send_request(CMD_COEF, 16'($urandom), cch, ctap, cval);
        if (int'(cch) < MAXC && int'(ctap) < TAPS) coef_mem[cch][ctap] = cval;
    endtask

    // block is idle once nothing is outstanding and the longest frame-end burst has drained
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (decisions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] cnt, logic [7:0] win);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CHANNEL_COUNT;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HALF_WINDOW;
        i_cfg_data <= win;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cnt_m = cnt;
        win_m = win[3:0];
    endtask

    task automatic run_phase(logic [7:0] cnt, logic [3:0] win, int n_items, bit long_hold);
        int c;
        int w;
        int r;
        settle();
        write_regs(cnt, {4'($urandom), win});
        c = live_count();
        w = live_window();
        for (int ch = 0; ch < c; ch++) begin
            for (int t = MAXW - w; t <= MAXW + w; t++) begin
                send_load(7'(ch), 5'(t), pick_coef(w));
                pace_sender();
            end
        end
        if (long_hold) hold_req = 1'b1;
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    send_load(7'($urandom_range(0, c - 1)),
                              5'($urandom_range(MAXW - w, MAXW + w)), pick_coef(w));
                else if (r < 8)
                    send_load(7'($urandom), 5'($urandom), 16'($urandom));
                else
                    send_load(7'($urandom), 5'd31, 16'($urandom));
            end else begin
                send_sample(pick_sample(), 1'b1);
            end
            pace_sender();
        end
    endtask

    // receiver: short stalls on its own pattern, one long hold-off on request
    initial begin : rx_pattern
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (n > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_d.ch    = o_m_axis_tdata[6:0];
            got_d.above = o_m_axis_tdata[7];
            got_d.last  = o_m_axis_tlast;
            if (decisions_due.size() == 0) begin
                $display("%0t: unexpected result channel %0d above %0b last %0b",
                         $realtime, got_d.ch, got_d.above, got_d.last);
                mismatch_cnt++;
            end else begin
                want_d = decisions_due.pop_front();
                if (got_d !== want_d) begin
                    $display("%0t: expected channel %0d above %0b last %0b, got %0d %0b %0b",
                             $realtime, want_d.ch, want_d.above, want_d.last,
                             got_d.ch, got_d.above, got_d.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $realtime, LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t row;
        decision_t d;
        // reset config first: window 8 means no decision for the first samples
        dir_tab[0]  = sample_row(16'hFFFF, 1'b0, 7'd0, 1'b0);
        dir_tab[1]  = sample_row(16'h0000, 1'b0, 7'd0, 1'b0);
        dir_tab[2]  = load_row(7'd127, 5'd30, 16'hFFFF);
        dir_tab[3]  = load_row(7'd0, 5'd31, 16'hFFFF);
        dir_tab[4]  = load_row(7'd127, 5'd0, 16'h0000);
        dir_tab[5]  = sample_row(16'h8000, 1'b0, 7'd0, 1'b0);
        // count lowered below position: frame closes with nothing to emit
        dir_tab[6]  = cfg_row(8'd3, 8'd0);
        dir_tab[7]  = sample_row(16'h1234, 1'b0, 7'd0, 1'b0);
        dir_tab[8]  = load_row(7'd0, 5'd15, 16'h0000);
        dir_tab[9]  = load_row(7'd1, 5'd15, 16'h4000);
        dir_tab[10] = load_row(7'd2, 5'd15, 16'hFFFF);
        dir_tab[11] = sample_row(16'hFFFF, 1'b1, 7'd0, 1'b1);
        dir_tab[12] = sample_row(16'h1234, 1'b1, 7'd1, 1'b0);
        dir_tab[13] = sample_row(16'h0000, 1'b1, 7'd2, 1'b0);
        dir_tab[14] = sample_row(16'h0001, 1'b1, 7'd0, 1'b1);
        // count 0 acts as 1; upper window bits ignored
        dir_tab[15] = cfg_row(8'd0, 8'hF0);
        dir_tab[16] = sample_row(16'h0007, 1'b0, 7'd0, 1'b0);
        dir_tab[17] = sample_row(16'h0000, 1'b1, 7'd0, 1'b0);
        dir_tab[18] = load_row(7'd0, 5'd15, 16'hFFFF);
        dir_tab[19] = sample_row(16'hFFFF, 1'b1, 7'd0, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            row = dir_tab[i];
            case (row.kind)
                ROW_CFG: begin
                    settle();
                    write_regs(row.cfg_cnt, row.cfg_win);
                end
                ROW_LOAD: begin
                    send_load(row.cch, row.ctap, row.cval);
                    pace_sender();
                end
                default: begin
                    send_sample(row.smp, 1'b0);
                    if (row.n_exp) begin
                        d.ch    = row.e_ch;
                        d.above = row.e_above;
                        d.last  = 1'b1;
                        decisions_due.push_back(d);
                    end
                    pace_sender();
                end
            endcase
        end

        run_phase(8'd7, 4'd2, 30, 1'b0);
        run_phase(8'd0, 4'd5, 14, 1'b0);
        run_phase(8'd255, 4'd15, 132, 1'b1);
        run_phase(8'd16, 4'd15, 30, 1'b0);
        run_phase(8'd128, 4'd0, 25, 1'b0);
        run_phase(8'd1, 4'd9, 10, 1'b0);
        run_phase(8'd33, 4'd7, 30, 1'b0);

        settle();
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
